### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define ASSERT_ALWAYS(lbl, expr)

`define ASSERT_IMPLIES(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/core/ckh_pkg.sv
// ----------------------------------------------------------------------------
// ckh_pkg
// types and constants shared by the cache key hasher modules
// ----------------------------------------------------------------------------
`default_nettype none

package ckh_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [31:0] FOLD_MULT = 32'h61C88647;

    localparam logic CFG_KEY_MODE = 1'b0;
    localparam logic CFG_SALT     = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic [7:0] key_length;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] hash_value;
        logic [7:0]  fan_index;
    } result_t;

    // one back-end operation
    typedef struct packed {
        logic        do_init;
        logic        do_mix;
        logic        do_fold;
        logic [31:0] word;
    } op_t;

endpackage

`default_nettype wire

### rtl/core/ckh_front.sv
// ----------------------------------------------------------------------------
// ckh_front
// accepts key bytes, packs them into words and issues mix and fold operations
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ckh_front import ckh_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    input  wire logic     key_mode,
    output logic          push,
    output op_t           push_op,
    input  wire logic     q_ready
);

    logic [31:0] buf_reg, buf_next;
    logic [1:0]  pos_reg, pos_next;
    logic        start_reg, start_next;
    logic        pend_valid_reg, pend_valid_next;
    op_t         pend_op_reg, pend_op_next;

    logic [31:0] cur_buf;
    logic [1:0]  cur_pos;
    logic        mix_a;
    logic [31:0] word_a;
    logic [7:0]  pb [3];
    logic [2:0]  pen;
    logic        need_a;
    logic        accept;
    op_t         op_a, op_b;

    always_comb
    begin
        pb[0]  = in_data.key_length;
        pb[1]  = in_data.data_byte;
        pb[2]  = 8'd0;
        pen[0] = start_reg & key_mode;
        pen[1] = in_data.data_valid;
        pen[2] = in_data.last & key_mode;

        cur_buf = start_reg ? 32'd0 : buf_reg;
        cur_pos = start_reg ? 2'd0 : pos_reg;
        mix_a   = 1'b0;
        word_a  = 32'd0;
        // prefix, data byte, terminator
        for (int i = 0; i < 3; i++)
        begin
            if (pen[i])
            begin
                cur_buf = cur_buf | ({24'd0, pb[i]} << {cur_pos, 3'b000});
                if (cur_pos == 2'd3)
                begin
                    mix_a   = 1'b1;
                    word_a  = cur_buf;
                    cur_buf = 32'd0;
                    cur_pos = 2'd0;
                end
                else
                begin
                    cur_pos = cur_pos + 2'd1;
                end
            end
        end

        need_a = mix_a | (start_reg & ~in_data.last);

        op_a.do_init = start_reg;
        op_a.do_mix  = mix_a;
        op_a.do_fold = 1'b0;
        op_a.word    = word_a;

        op_b.do_init = start_reg & ~need_a;
        op_b.do_mix  = (cur_pos != 2'd0);
        op_b.do_fold = 1'b1;
        op_b.word    = cur_buf;
    end

    assign in_stall = pend_valid_reg | ~q_ready;
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        push            = 1'b0;
        push_op         = op_a;
        pend_valid_next = pend_valid_reg;
        pend_op_next    = pend_op_reg;
        buf_next        = buf_reg;
        pos_next        = pos_reg;
        start_next      = start_reg;

        if (pend_valid_reg)
        begin
            push    = q_ready;
            push_op = pend_op_reg;
            if (q_ready)
            begin
                pend_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            push    = need_a | in_data.last;
            push_op = need_a ? op_a : op_b;
            if (need_a && in_data.last)
            begin
                pend_valid_next = 1'b1;
                pend_op_next    = op_b;
            end
            if (in_data.last)
            begin
                buf_next   = 32'd0;
                pos_next   = 2'd0;
                start_next = 1'b1;
            end
            else
            begin
                buf_next   = cur_buf;
                pos_next   = cur_pos;
                start_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg        <= 32'd0;
            pos_reg        <= 2'd0;
            start_reg      <= 1'b1;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg        <= buf_next;
            pos_reg        <= pos_next;
            start_reg      <= start_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_op_reg <= pend_op_next;
    end

    // a held second operation always closes the key
    `ASSERT_IMPLIES(a_pend_is_fold, pend_valid_reg, pend_op_reg.do_fold && start_reg)

endmodule

`default_nettype wire

### rtl/core/ckh_queue.sv
// ----------------------------------------------------------------------------
// ckh_queue
// short operation queue between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ckh_queue import ckh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire op_t  push_op,
    output logic      q_ready,
    output logic      q_valid,
    output op_t       q_op,
    input  wire logic pop
);

    op_t            entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_push, do_pop;

    assign q_ready = (count_reg != QCW'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_op    = entry_reg[rd_ptr_reg];
    assign do_push = push & q_ready;
    assign do_pop  = pop & q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // fill count never exceeds the queue depth
    `ASSERT_ALWAYS(a_q_count, count_reg <= QCW'(QDEPTH))

endmodule

`default_nettype wire

### rtl/core/ckh_back.sv
// ----------------------------------------------------------------------------
// ckh_back
// runs the word mix on the state pair and folds it into the result
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ckh_back import ckh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire op_t         q_op,
    output logic             pop,
    input  wire logic        key_mode,
    input  wire logic [31:0] salt,
    output logic             out_valid,
    input  wire logic        out_stall,
    output result_t          out_data
);

    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic        fold_req_reg, fold_req_next;
    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] p1_reg;
    logic [31:0] ys_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] hash_reg;

    logic [31:0] x_in, y_in, x1, y1, x2, yr, y2;
    logic        s1_load, s1_adv;

    assign pop = q_valid & ~fold_req_reg;

    always_comb
    begin
        x_in = q_op.do_init ? 32'd0 : x_reg;
        y_in = q_op.do_init ? (key_mode ? 32'd0 : salt) : y_reg;
        x1   = x_in ^ q_op.word;
        y1   = y_in ^ x1;
        x2   = {x1[24:0], x1[31:25]} + y1;
        yr   = {y1[11:0], y1[31:12]};
        y2   = yr + {yr[28:0], 3'b000};

        x_next = x_reg;
        y_next = y_reg;
        if (pop)
        begin
            x_next = q_op.do_mix ? x2 : x_in;
            y_next = q_op.do_mix ? y2 : y_in;
        end
    end

    assign s1_adv  = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign s1_load = fold_req_reg & (~s1_valid_reg | s1_adv);

    always_comb
    begin
        fold_req_next = fold_req_reg;
        if (pop && q_op.do_fold)
        begin
            fold_req_next = 1'b1;
        end
        else if (s1_load)
        begin
            fold_req_next = 1'b0;
        end

        s1_valid_next = s1_load | (s1_valid_reg & ~s1_adv);

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= 32'd0;
            y_reg         <= 32'd0;
            fold_req_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            fold_req_reg  <= fold_req_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // fold multiplies, one per stage
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            p1_reg <= x_reg * FOLD_MULT;
            ys_reg <= y_reg;
        end
        if (s1_adv)
        begin
            hash_reg <= (ys_reg ^ p1_reg) * FOLD_MULT;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_data.hash_value = hash_reg;
    assign out_data.fan_index  = hash_reg[7:0];

    // a fold request is taken as soon as the first fold stage is free
    `ASSERT_NEXT(a_fold_taken, fold_req_reg && !s1_valid_reg, !fold_req_reg)
    // the first fold stage only fills from a pending request
    `ASSERT_IMPLIES(a_s1_source, $rose(s1_valid_reg), $past(fold_req_reg))

endmodule

`default_nettype wire

### rtl/core/cache_key_hasher.sv
// result path: a key's fold goes through the queue, the fold request
// register, the first fold stage and the output register, held first in the
// front end when the last item also closes a word; throughput: one item per
// cycle while in_stall is low; popping stops while a fold request waits
// reset: asynchronous, clears queue, mix state and output; key_mode and salt
// reset to 0 and the next item starts a new key
// ----------------------------------------------------------------------------
// cache_key_hasher
// streaming key hasher: byte packing front end, mix and fold back end
// ----------------------------------------------------------------------------
`default_nettype none

module cache_key_hasher import ckh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output result_t          out_data
);

    logic        key_mode_reg, key_mode_next;
    logic [31:0] salt_reg, salt_next;

    logic        push, q_ready, q_valid, pop;
    op_t         push_op, q_op;

    always_comb
    begin
        key_mode_next = key_mode_reg;
        salt_next     = salt_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_KEY_MODE: key_mode_next = cfg_data[0];
                CFG_SALT:     salt_next     = cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mode_reg <= 1'b0;
            salt_reg     <= 32'd0;
        end
        else
        begin
            key_mode_reg <= key_mode_next;
            salt_reg     <= salt_next;
        end
    end

    ckh_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .key_mode (key_mode_reg),
        .push     (push),
        .push_op  (push_op),
        .q_ready  (q_ready)
    );

    ckh_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .q_ready (q_ready),
        .q_valid (q_valid),
        .q_op    (q_op),
        .pop     (pop)
    );

    ckh_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .pop       (pop),
        .key_mode  (key_mode_reg),
        .salt      (salt_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
